### sv/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg: shared types and constants for the shortest path search
// Holds graph sizes, field widths, action codes and the cell control struct.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int NODES     = 32;
  localparam int EDGES     = 128;
  localparam int COST_BITS = 16;

  localparam int NODE_W = 5;
  localparam int ID_W   = 7;
  localparam int DIST_W = 22;
  localparam int MAX_OUT = 31;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_FIND   = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Control broadcast from the sequencer to every node cell
  typedef struct packed {
    logic              init;    // clear flags, seed start
    logic [NODE_W-1:0] start;
    logic              relax;   // edge relaxation this cycle
    logic [NODE_W-1:0] cur;     // settling node
    logic [NODE_W-1:0] adj;     // neighbour of the scanned edge
    logic [DIST_W-1:0] sum;     // candidate distance
    logic [ID_W-1:0]   id;      // scanned edge id
    logic              settle;  // mark cur settled
  } cell_ctl_t;

  // Candidate passed along the cell chain for the minimum search
  typedef struct packed {
    logic              ok;
    logic [NODE_W-1:0] node;
    logic [DIST_W-1:0] dist_v;
  } cand_t;

endpackage

### sv/sps_cell.sv
// ----------------------------------------------------------------------------
// sps_cell: one node cell
// Holds distance, parent edge and flags of one node; forwards the best
// unsettled candidate to its neighbour.
// ----------------------------------------------------------------------------
module sps_cell
  import sps_pkg::*;
#(
  parameter logic [NODE_W-1:0] NODE_ID = '0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cell_ctl_t       ctl,
  input  cand_t           cand_in,
  output cand_t           cand_out,
  output logic [DIST_W-1:0] node_dist,
  output logic [ID_W-1:0]   parent,
  output logic              settled,
  output logic              reached
);

  logic [DIST_W-1:0] dist_r;
  logic [ID_W-1:0]   parent_r;
  logic              settled_r, reached_r;
  logic              better;

  assign better = ctl.relax && ctl.adj == NODE_ID && !settled_r &&
                  (!reached_r || ctl.sum < dist_r);

  // Update flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settled_r <= 1'b0;
      reached_r <= 1'b0;
    end else if (ctl.init) begin
      settled_r <= 1'b0;
      reached_r <= ctl.start == NODE_ID;
    end else begin
      if (better) reached_r <= 1'b1;
      if (ctl.settle && ctl.cur == NODE_ID) settled_r <= 1'b1;
    end
  end

  // Hold distance and parent
  always_ff @(posedge clk) begin
    if (ctl.init && ctl.start == NODE_ID) begin
      dist_r <= '0;
    end else if (!ctl.init && better) begin
      dist_r   <= ctl.sum;
      parent_r <= ctl.id;
    end
  end

  // Pass on the better candidate; lower ids sit earlier, so ties keep cand_in
  always_comb begin
    cand_out = cand_in;
    if (reached_r && !settled_r && (!cand_in.ok || dist_r < cand_in.dist_v)) begin
      cand_out.ok     = 1'b1;
      cand_out.node   = NODE_ID;
      cand_out.dist_v = dist_r;
    end
  end

  assign node_dist = dist_r;
  assign parent    = parent_r;
  assign settled   = settled_r;
  assign reached   = reached_r;

endmodule

### sv/shortest_path_search.sv
// A query settles one node per round (a minimum search, then a scan of every
//   loaded edge), then walks the path back from the goal, each edge through
//   S_TRD, S_TWT and S_TOUT (S_ONE for a single result); output stalls hold it.
// Throughput: one request at a time; the edge memory read port sets the scan.
// Minimum search walks the cell chain in NODES/8 registered hops of 8 cells.
// Reset clears edge count, flags and sequencer; edge memory is not cleared.
// ----------------------------------------------------------------------------
// shortest_path_search: Dijkstra over a loaded multigraph
// Sequencer, edge memory and a chain of node cells.
// ----------------------------------------------------------------------------
module shortest_path_search
  import sps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [4:0]  in_end_a,
  input  logic [4:0]  in_end_b,
  input  logic [15:0] in_edge_cost,
  input  logic [4:0]  in_start_node,
  input  logic [4:0]  in_goal_node,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_edge_id,
  output logic        out_edge_valid,
  output logic        out_path_found,
  output logic [21:0] out_total_cost,
  output logic        out_last
);

  localparam int NS   = 32;            // cells in use (node field width)
  localparam int CW   = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int CNTW = $clog2(EDGES + 1);
  localparam int GRP  = 8;
  localparam int NGRP = (NS + GRP - 1) / GRP;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam logic [COST_BITS-1:0] CMAX = {COST_BITS{1'b1}};

  localparam logic [3:0] S_IDLE = 4'd0, S_MIN = 4'd1, S_PICK = 4'd2,
                         S_RD = 4'd3, S_REL = 4'd4, S_SET = 4'd5,
                         S_TRD = 4'd6, S_TWT = 4'd7, S_TOUT = 4'd8,
                         S_ONE = 4'd9;

  logic [3:0] state_r, state_nxt;

  // Edge memory
  logic [2*NODE_W-1:0]  ends_mem [EDGES];
  logic [COST_BITS-1:0] wt_mem   [EDGES];
  logic [2*NODE_W-1:0]  rd_ends_r;
  logic [COST_BITS-1:0] rd_wt_r;
  logic [CW-1:0]        rd_addr;
  logic [CNTW-1:0]      cnt_r;

  logic [NODE_W-1:0] start_r, goal_r, cur_r, walk_r;
  logic [DIST_W-1:0] cur_dist_r;
  logic [CNTW-1:0]   scan_r;
  logic [CW-1:0]     id_r;
  logic [GW-1:0]     grp_r;
  cand_t             best_r;
  logic [5:0]        steps_r, k_r;

  cell_ctl_t ctl;
  cand_t     chain [NS+1];
  logic [DIST_W-1:0] c_dist [NS];
  logic [ID_W-1:0]   c_par  [NS];
  logic [NS-1:0]     c_set, c_rch;

  logic acc;
  assign in_ready = state_r == S_IDLE && !out_valid;
  assign acc = in_valid && in_ready;

  logic add_ok;
  assign add_ok = acc && in_action == ACT_ADD && cnt_r < CNTW'(EDGES) &&
                  32'(in_end_a) < NODES && 32'(in_end_b) < NODES;

  // Write edges, count them
  always_ff @(posedge clk) begin
    if (add_ok) begin
      ends_mem[cnt_r[CW-1:0]] <= {in_end_b, in_end_a};
      wt_mem[cnt_r[CW-1:0]]   <= (in_edge_cost > 16'(CMAX)) ? CMAX
                                 : COST_BITS'(in_edge_cost);
    end
    rd_ends_r <= ends_mem[rd_addr];
    rd_wt_r   <= wt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (acc && in_action == ACT_CLEAR) cnt_r <= '0;
    else if (add_ok) cnt_r <= cnt_r + 1'b1;
  end

  // Node cells
  assign chain[0] = '0;
  for (genvar g = 0; g < NS; g++) begin : g_cell
    sps_cell #(.NODE_ID(NODE_W'(g))) u_cell (
      .clk, .rst_n, .ctl,
      .cand_in(g % GRP == 0 ? cand_t'('0) : chain[g]),
      .cand_out(chain[g+1]),
      .node_dist(c_dist[g]), .parent(c_par[g]),
      .settled(c_set[g]), .reached(c_rch[g])
    );
  end

  // Group output of the currently walked group of eight cells
  cand_t grp_best;
  always_comb begin
    grp_best = '0;
    for (int i = 0; i < NGRP; i++)
      if (GW'(i) == grp_r) grp_best = chain[(i*GRP+GRP > NS) ? NS : i*GRP+GRP];
  end

  // Decode the scanned edge
  logic [NODE_W-1:0] ea, eb, adj;
  logic              hit;
  logic [DIST_W:0]   sum_w;
  assign ea = rd_ends_r[NODE_W-1:0];
  assign eb = rd_ends_r[2*NODE_W-1:NODE_W];
  assign hit = (ea == cur_r) || (eb == cur_r);
  assign adj = (ea == cur_r) ? eb : ea;
  assign sum_w = {1'b0, cur_dist_r} + (DIST_W+1)'(rd_wt_r);

  always_comb begin
    ctl = '0;
    ctl.init   = acc && in_action == ACT_FIND;
    ctl.start  = in_start_node;
    ctl.relax  = state_r == S_REL && hit && 32'(adj) < NODES;
    ctl.cur    = cur_r;
    ctl.adj    = adj;
    ctl.sum    = sum_w[DIST_W] ? DIST_MAX : sum_w[DIST_W-1:0];
    ctl.id     = ID_W'(id_r);
    ctl.settle = state_r == S_SET;
  end

  // Hold the parent edge address for the whole path step
  always_comb begin
    rd_addr = id_r;
    if (state_r == S_TRD || state_r == S_TWT || state_r == S_TOUT)
      rd_addr = CW'(c_par[walk_r]);
  end

  // Output register
  logic ov_r, oev_r, opf_r, olast_r;
  logic [ID_W-1:0]   oid_r;
  logic [DIST_W-1:0] ocost_r;
  assign out_valid = ov_r;
  assign out_edge_id = oid_r;
  assign out_edge_valid = oev_r;
  assign out_path_found = opf_r;
  assign out_total_cost = ocost_r;
  assign out_last = olast_r;

  logic bad_q;
  assign bad_q = 32'(in_start_node) >= NODES || 32'(in_goal_node) >= NODES;

  function automatic logic bad_start_goal();
    return 32'(start_r) >= NODES || 32'(goal_r) >= NODES;
  endfunction

  logic [NODE_W-1:0] nxt_walk;
  logic walk_end, walk_last;
  assign nxt_walk = (ea == walk_r) ? eb : ea;
  assign walk_end = nxt_walk == start_r || steps_r == 6'(NODES - 1) ||
                    k_r == 6'(MAX_OUT - 1);
  assign walk_last = walk_end || 32'(nxt_walk) >= NODES;

  logic out_load;
  assign out_load = (state_r == S_TOUT && (!ov_r || out_ready)) || state_r == S_ONE;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (acc && in_action == ACT_FIND) state_nxt = bad_q ? S_ONE : S_MIN;
      S_MIN:  if (ov_r == 1'b0 && grp_r == GW'(NGRP-1)) state_nxt = S_PICK;
      S_PICK: begin
        if (c_set[goal_r] && start_r != goal_r) state_nxt = S_TRD;
        else if (c_set[goal_r] || !best_r.ok) state_nxt = S_ONE;
        else if (cnt_r == '0) state_nxt = S_SET;
        else state_nxt = S_RD;
      end
      S_RD:   state_nxt = S_REL;
      S_REL:  state_nxt = (scan_r == '0) ? S_SET : S_RD;
      S_SET:  state_nxt = S_MIN;
      S_TRD:  state_nxt = S_TWT;
      S_TWT:  state_nxt = S_TOUT;
      S_TOUT: if (!ov_r || out_ready) state_nxt = walk_last ? S_IDLE : S_TRD;
      S_ONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) ov_r <= 1'b1;
      else if (ov_r && out_ready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: if (acc && in_action == ACT_FIND) begin
          start_r <= in_start_node; goal_r <= in_goal_node;
          grp_r <= '0; best_r <= '0;
        end
        S_MIN: if (!ov_r) begin
          if (grp_best.ok && (!best_r.ok || grp_best.dist_v < best_r.dist_v))
            best_r <= grp_best;
          grp_r <= grp_r + 1'b1;
        end
        S_PICK: begin
          cur_r <= best_r.node; cur_dist_r <= best_r.dist_v;
          scan_r <= cnt_r; id_r <= CW'(cnt_r - 1'b1);
          if (c_set[goal_r] && start_r != goal_r) begin
            walk_r <= goal_r; steps_r <= '0; k_r <= '0;
          end
        end
        S_RD: scan_r <= scan_r - 1'b1;
        S_REL: id_r <= id_r - 1'b1;
        S_SET: begin grp_r <= '0; best_r <= '0; end
        S_TWT: ;
        S_TOUT: if (!ov_r || out_ready) begin
          oid_r <= ID_W'(c_par[walk_r]); oev_r <= 1'b1;
          opf_r <= 1'b1; ocost_r <= c_dist[goal_r];
          olast_r <= walk_last;
          walk_r <= nxt_walk; steps_r <= steps_r + 1'b1; k_r <= k_r + 1'b1;
        end
        S_ONE: begin
          oid_r <= '0; oev_r <= 1'b0; olast_r <= 1'b1;
          if (!bad_start_goal() && c_set[goal_r] && start_r == goal_r) begin
            opf_r <= 1'b1; ocost_r <= '0;
          end else begin
            opf_r <= 1'b0; ocost_r <= DIST_MAX;
          end
        end
        default: ;
      endcase
    end
  end

  // Checks
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_edge_id))
    else $error("result dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready)
    else $error("request accepted during search");
  a_notfound_cost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_path_found |-> out_total_cost == DIST_MAX && out_last)
    else $error("bad not-found result");
  a_settled_reached: assert property (@(posedge clk) disable iff (!rst_n)
    (c_set & ~c_rch) == '0)
    else $error("settled node never reached");

endmodule

### verif/sps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_checker: path result checker for the shortest path search
// Watches accepted requests, runs its own Dijkstra on a shadow graph and
// compares every accepted path result against the oldest expected one.
// ----------------------------------------------------------------------------
module sps_checker
  import sps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [4:0]  in_end_a,
  input  logic [4:0]  in_end_b,
  input  logic [15:0] in_edge_cost,
  input  logic [4:0]  in_start_node,
  input  logic [4:0]  in_goal_node,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [6:0]  out_edge_id,
  input  logic        out_edge_valid,
  input  logic        out_path_found,
  input  logic [21:0] out_total_cost,
  input  logic        out_last,
  output int          fail_count,
  output int          pending
);

  localparam int N_NODES = 32;
  localparam int N_EDGES = 128;

  typedef struct packed {
    logic [ID_W-1:0]   edge_id;
    logic              edge_valid;
    logic              path_found;
    logic [DIST_W-1:0] total_cost;
    logic              last;
  } path_step_t;

  // Shadow graph
  logic [NODE_W-1:0] g_end_a [N_EDGES];
  logic [NODE_W-1:0] g_end_b [N_EDGES];
  logic [15:0]       g_cost  [N_EDGES];
  int                g_count;

  path_step_t path_q[$];

  assign pending = path_q.size();

  function automatic path_step_t mk_step(logic [ID_W-1:0] id, logic v, logic f,
                                         logic [DIST_W-1:0] c, logic l);
    path_step_t s;
    s.edge_id = id; s.edge_valid = v; s.path_found = f;
    s.total_cost = c; s.last = l;
    return s;
  endfunction

  // Run Dijkstra and queue the path edges, goal back to start (one step if none or src == dst)
  task automatic predict_path(logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst);
    logic [DIST_W-1:0] d_node [N_NODES];
    logic [ID_W-1:0]   parent [N_NODES];
    logic              done [N_NODES];
    logic              seen [N_NODES];
    logic [ID_W-1:0]   hops [$];
    logic [DIST_W:0]   sum;
    int cur, nb, k, node;
    for (int n = 0; n < N_NODES; n++) begin
      done[n] = 0; seen[n] = 0; d_node[n] = '0; parent[n] = '0;
    end
    d_node[src] = '0;
    seen[src] = 1;
    while (!done[dst]) begin
      cur = -1;
      for (int n = 0; n < N_NODES; n++)
        if (seen[n] && !done[n] && (cur < 0 || d_node[n] < d_node[cur])) cur = n;
      if (cur < 0) break;
      for (int e = g_count - 1; e >= 0; e--) begin
        if (g_end_a[e] == cur) nb = g_end_b[e];
        else if (g_end_b[e] == cur) nb = g_end_a[e];
        else continue;
        if (done[nb]) continue;
        sum = d_node[cur] + g_cost[e];
        if (sum > DIST_MAX) sum = DIST_MAX;
        if (!seen[nb] || sum[DIST_W-1:0] < d_node[nb]) begin
          d_node[nb] = sum[DIST_W-1:0];
          parent[nb] = ID_W'(e);
          seen[nb] = 1;
        end
      end
      done[cur] = 1;
    end
    if (!done[dst]) begin
      path_q = {path_q, mk_step('0, 0, 0, DIST_MAX, 1)};
    end else if (src == dst) begin
      path_q = {path_q, mk_step('0, 0, 1, '0, 1)};
    end else begin
      node = dst;
      for (int s = 0; node != src && s < N_NODES && hops.size() < MAX_OUT; s++) begin
        hops = {hops, parent[node]};
        node = (g_end_a[parent[node]] == node) ? g_end_b[parent[node]]
                                               : g_end_a[parent[node]];
      end
      k = hops.size();
      for (int i = 0; i < k; i++)
        path_q = {path_q, mk_step(hops[i], 1, 1, d_node[dst], i == k - 1)};
    end
  endtask

  // Track requests and predict
  always @(posedge clk) begin
    if (!rst_n) begin
      g_count = 0;
    end else if (in_valid && in_ready) begin
      case (in_action)
        ACT_CLEAR: g_count = 0;
        ACT_ADD: begin
          if (g_count < N_EDGES) begin
            g_end_a[g_count] = in_end_a;
            g_end_b[g_count] = in_end_b;
            g_cost[g_count] = in_edge_cost;
            g_count = g_count + 1;
          end
        end
        ACT_FIND: predict_path(in_start_node, in_goal_node);
        default: ;
      endcase
    end
  end

  // Compare accepted results
  always @(posedge clk) begin
    path_step_t exp_s;
    if (!rst_n) begin
      fail_count = 0;
    end else if (out_valid && out_ready) begin
      if (path_q.size() == 0) begin
        $error("unexpected result: edge_id %0d", out_edge_id);
        fail_count++;
      end else begin
        exp_s = path_q.pop_front();
        if (out_edge_id !== exp_s.edge_id) begin
          $error("edge_id expected %0d got %0d", exp_s.edge_id, out_edge_id);
          fail_count++;
        end
        if (out_edge_valid !== exp_s.edge_valid) begin
          $error("edge_valid expected %0d got %0d", exp_s.edge_valid, out_edge_valid);
          fail_count++;
        end
        if (out_path_found !== exp_s.path_found) begin
          $error("path_found expected %0d got %0d", exp_s.path_found, out_path_found);
          fail_count++;
        end
        if (out_total_cost !== exp_s.total_cost) begin
          $error("total_cost expected %0d got %0d", exp_s.total_cost, out_total_cost);
          fail_count++;
        end
        if (out_last !== exp_s.last) begin
          $error("last expected %0d got %0d", exp_s.last, out_last);
          fail_count++;
        end
      end
    end
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: shortest path search testbench
// Loads graphs edge by edge, issues path requests with random idling and a
// long result hold-off; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import sps_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_action = ACT_CLEAR;
  logic [4:0]  in_end_a = '0;
  logic [4:0]  in_end_b = '0;
  logic [15:0] in_edge_cost = '0;
  logic [4:0]  in_start_node = '0;
  logic [4:0]  in_goal_node = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [6:0]  out_edge_id;
  logic        out_edge_valid;
  logic        out_path_found;
  logic [21:0] out_total_cost;
  logic        out_last;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          sent = 0;
  bit          calm = 0;
  bit          hold_off = 0;

  localparam int CYCLE_LIMIT = 3000000;

  always #10 clk = ~clk;

  shortest_path_search uut (.*);

  sps_checker checker_i (.*);

  // Guard against a hung block
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Drive result ready with random stalls and a long hold-off
  always @(negedge clk) begin
    if (hold_off) out_ready <= 0;
    else out_ready <= calm || ($urandom_range(99) >= 23);
  end

  // Offer one request, idling first at random; valid stays up between requests
  task automatic send_request(logic [1:0] act, logic [4:0] a, logic [4:0] b,
                              logic [15:0] c, logic [4:0] s, logic [4:0] g);
    sent++;
    if (!calm && $urandom_range(99) < 23) begin
      in_valid <= 0;
      @(negedge clk);
      while ($urandom_range(99) < 23) @(negedge clk);
    end
    in_valid <= 1;
    in_action <= act; in_end_a <= a; in_end_b <= b;
    in_edge_cost <= c; in_start_node <= s; in_goal_node <= g;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_edge(int a, int b, int c);
    send_request(ACT_ADD, 5'(a), 5'(b), 16'(c), 5'($urandom), 5'($urandom));
  endtask

  task automatic find_path(int s, int g);
    send_request(ACT_FIND, 5'($urandom), 5'($urandom), 16'($urandom), 5'(s), 5'(g));
  endtask

  // Clear, build a chain of the given length, then random extra edges
  task automatic random_graph(int chain, int extra, int cost_max);
    int perm [32];
    int j, t;
    send_request(ACT_CLEAR, 5'($urandom), 5'($urandom), 16'($urandom),
                 5'($urandom), 5'($urandom));
    for (int i = 0; i < 32; i++) perm[i] = i;
    for (int i = 31; i > 0; i--) begin
      j = $urandom_range(i); t = perm[i]; perm[i] = perm[j]; perm[j] = t;
    end
    for (int i = 0; i < chain; i++)
      add_edge(perm[i], perm[i + 1], $urandom_range(cost_max));
    for (int i = 0; i < extra; i++)
      add_edge($urandom_range(31), $urandom_range(31), $urandom_range(cost_max));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: empty graph, self query, extremes, maximum costs, long path
    find_path(0, 31);
    find_path(5, 5);
    add_edge(0, 31, 16'hFFFF);
    add_edge(31, 0, 3);
    add_edge(7, 7, 0);
    find_path(31, 0);
    find_path(0, 7);
    send_request(ACT_UNUSED, 5'h1F, 5'h1F, 16'hFFFF, 5'h1F, 5'h1F);
    send_request(ACT_CLEAR, '0, '0, '0, '0, '0);
    for (int i = 0; i < 31; i++) add_edge(i, i + 1, 16'hFFFF);
    find_path(0, 31);
    find_path(31, 0);
    calm = 1;
    for (int i = 0; i < 16; i++) add_edge(i, 31 - i, 16'hFFFF);
    add_edge(1, 2, 1);
    find_path(3, 28);
    calm = 0;

    // Random graphs; the first phase holds the receiver off for a long stretch
    for (int ph = 0; sent < 140; ph++) begin
      random_graph($urandom_range(31), $urandom_range(12),
                   (ph % 3 == 0) ? 65535 : $urandom_range(1, 50));
      if (ph == 0) begin
        hold_off = 1;
        fork
          begin repeat (3000) @(negedge clk); hold_off = 0; end
        join_none
      end
      for (int q = 0; q < 6; q++)
        find_path($urandom_range(31), $urandom_range(31));
    end
    in_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
